>>> hw/rtl/qtrp_pkg.sv
// ============================================================================
// qtrp_pkg
// Shared types and constants of the response record parser: beat formats,
// parser modes, record tracking codes and summary status codes.
// ============================================================================
`default_nettype none

package qtrp_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CAPACITY = 1'd1;

    localparam logic [7:0]  WANTED_TYPE_RESET    = 8'd1;
    localparam logic [15:0] VALUE_CAPACITY_RESET = 16'd2;

    localparam logic [15:0] RECORDS_START = 16'd4;
    localparam logic [15:0] LAST_SKIP_POS = RECORDS_START - 16'd1;
    localparam logic [7:0]  RESULT_TYPE   = 8'd2;
    localparam logic [15:0] RESULT_LEN    = 16'd4;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef enum logic [1:0] {
        MODE_SKIP   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_VALUE  = 2'd2
    } t_rec_mode;

    typedef enum logic [1:0] {
        RES_NONE    = 2'd0,
        RES_COLLECT = 2'd1,
        RES_BAD     = 2'd2,
        RES_DONE    = 2'd3
    } t_res_seen;

    typedef enum logic [1:0] {
        WNT_NONE = 2'd0,
        WNT_EMIT = 2'd1,
        WNT_BIG  = 2'd2,
        WNT_DONE = 2'd3
    } t_wnt_seen;

    typedef enum logic [2:0] {
        RS_OK        = 3'd0,
        RS_SHORT     = 3'd1,
        RS_NO_RESULT = 3'd2,
        RS_BAD_SIZE  = 3'd3,
        RS_MODEM_ERR = 3'd4
    } t_result_status;

    typedef enum logic [1:0] {
        WS_FOUND     = 2'd0,
        WS_NOT_FOUND = 2'd1,
        WS_TOO_BIG   = 2'd2,
        WS_TRUNCATED = 2'd3
    } t_wanted_status;

    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value_byte;
        logic [15:0] value_offset;
        logic [15:0] message_id;
        logic [2:0]  result_status;
        logic [15:0] modem_error;
        logic [1:0]  wanted_status;
        logic [15:0] wanted_length;
        logic        end_flag;
    } t_out_beat;

    typedef struct packed {
        logic [1:0] count;
        t_out_beat  first;
        t_out_beat  second;
    } t_push_pair;

endpackage

`default_nettype wire

>>> hw/rtl/qtrp_core.sv
// ============================================================================
// qtrp_core
// Parser state and per-byte step logic: tracks position, record headers and
// record values, and produces up to two result beats per input byte.
// ============================================================================
`default_nettype none

module qtrp_core
    import qtrp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    input  wire t_in_beat              i_beat,
    output t_push_pair                 o_push
);

    logic [7:0]  r_wanted_type;
    logic [15:0] r_value_cap;

    logic [15:0] r_byte_pos,    n_byte_pos;
    logic [15:0] r_next_start,  n_next_start;
    logic [7:0]  r_rec_type,    n_rec_type;
    logic [15:0] r_rec_len,     n_rec_len;
    t_rec_mode   r_mode,        n_mode;
    logic [15:0] r_id,          n_id;
    logic [31:0] r_words,       n_words;
    t_res_seen   r_res_seen,    n_res_seen;
    t_wnt_seen   r_wnt_seen,    n_wnt_seen;
    logic [15:0] r_wanted_len,  n_wanted_len;

    logic [15:0]    rel_pos;
    logic [15:0]    hdr_len;
    logic           short_msg;
    logic           emit;
    t_result_status res_status;
    t_wanted_status wnt_status;
    t_out_beat      value_beat;
    t_out_beat      summary_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_type <= WANTED_TYPE_RESET;
            r_value_cap   <= VALUE_CAPACITY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WANTED_TYPE:    r_wanted_type <= i_cfg_data[7:0];
                CFG_VALUE_CAPACITY: r_value_cap   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos   <= '0;
            r_next_start <= RECORDS_START;
            r_rec_type   <= '0;
            r_rec_len    <= '0;
            r_mode       <= MODE_SKIP;
            r_id         <= '0;
            r_words      <= '0;
            r_res_seen   <= RES_NONE;
            r_wnt_seen   <= WNT_NONE;
            r_wanted_len <= '0;
        end else if (i_valid) begin
            r_byte_pos   <= n_byte_pos;
            r_next_start <= n_next_start;
            r_rec_type   <= n_rec_type;
            r_rec_len    <= n_rec_len;
            r_mode       <= n_mode;
            r_id         <= n_id;
            r_words      <= n_words;
            r_res_seen   <= n_res_seen;
            r_wnt_seen   <= n_wnt_seen;
            r_wanted_len <= n_wanted_len;
        end
    end

    always_comb begin
        n_byte_pos   = r_byte_pos + 16'd1;
        n_next_start = r_next_start;
        n_rec_type   = r_rec_type;
        n_rec_len    = r_rec_len;
        n_mode       = r_mode;
        n_id         = r_id;
        n_words      = r_words;
        n_res_seen   = r_res_seen;
        n_wnt_seen   = r_wnt_seen;
        n_wanted_len = r_wanted_len;
        rel_pos      = r_byte_pos - r_next_start;
        hdr_len      = {i_beat.data_byte, r_rec_len[7:0]};
        short_msg    = 1'b0;
        emit         = 1'b0;

        unique case (r_mode)
            MODE_SKIP: begin
                if (r_byte_pos == 16'd0) begin
                    n_id      = {8'd0, i_beat.data_byte};
                    short_msg = i_beat.last_byte;
                end else if (r_byte_pos == 16'd1) begin
                    n_id = {i_beat.data_byte, r_id[7:0]};
                end else if (r_byte_pos == LAST_SKIP_POS) begin
                    n_mode       = MODE_HEADER;
                    n_next_start = RECORDS_START;
                end
            end
            MODE_HEADER: begin
                if (rel_pos == 16'd0) begin
                    n_rec_type = i_beat.data_byte;
                end else if (rel_pos == 16'd1) begin
                    n_rec_len = {8'd0, i_beat.data_byte};
                end else begin
                    n_rec_len = hdr_len;
                    if (!i_beat.last_byte) begin
                        if (r_rec_type == r_wanted_type && r_wnt_seen == WNT_NONE) begin
                            n_wanted_len = hdr_len;
                            if (hdr_len > r_value_cap) begin
                                n_wnt_seen = WNT_BIG;
                            end else if (hdr_len == 16'd0) begin
                                n_wnt_seen = WNT_DONE;
                            end else begin
                                n_wnt_seen = WNT_EMIT;
                            end
                        end
                        if (r_rec_type == RESULT_TYPE && r_res_seen == RES_NONE) begin
                            n_words    = '0;
                            n_res_seen = (hdr_len == RESULT_LEN) ? RES_COLLECT : RES_BAD;
                        end
                        n_next_start = r_byte_pos + 16'd1;
                        n_mode       = (hdr_len == 16'd0) ? MODE_HEADER : MODE_VALUE;
                    end
                end
            end
            MODE_VALUE: begin
                emit = (r_wnt_seen == WNT_EMIT);
                if (r_res_seen == RES_COLLECT && rel_pos < RESULT_LEN) begin
                    n_words[8*rel_pos[1:0] +: 8] = i_beat.data_byte;
                end
                if (rel_pos == r_rec_len - 16'd1) begin
                    if (r_wnt_seen == WNT_EMIT) begin
                        n_wnt_seen = WNT_DONE;
                    end
                    if (r_res_seen == RES_COLLECT) begin
                        n_res_seen = RES_DONE;
                    end
                    n_next_start = r_byte_pos + 16'd1;
                    n_mode       = MODE_HEADER;
                end
            end
            default: ;
        endcase

        if (short_msg) begin
            res_status = RS_SHORT;
        end else if (n_res_seen == RES_NONE) begin
            res_status = RS_NO_RESULT;
        end else if (n_res_seen != RES_DONE) begin
            res_status = RS_BAD_SIZE;
        end else if (n_words[15:0] != 16'd0) begin
            res_status = RS_MODEM_ERR;
        end else begin
            res_status = RS_OK;
        end

        unique case (n_wnt_seen)
            WNT_NONE: wnt_status = WS_NOT_FOUND;
            WNT_EMIT: wnt_status = WS_TRUNCATED;
            WNT_BIG:  wnt_status = WS_TOO_BIG;
            default:  wnt_status = WS_FOUND;
        endcase

        value_beat              = '0;
        value_beat.kind         = KIND_VALUE;
        value_beat.value_byte   = i_beat.data_byte;
        value_beat.value_offset = rel_pos;

        summary_beat               = '0;
        summary_beat.kind          = KIND_SUMMARY;
        summary_beat.message_id    = short_msg ? 16'd0 : n_id;
        summary_beat.result_status = res_status;
        summary_beat.modem_error   = (res_status == RS_MODEM_ERR) ? n_words[31:16] : 16'd0;
        summary_beat.wanted_status = wnt_status;
        summary_beat.wanted_length = (n_wnt_seen == WNT_NONE) ? 16'd0 : n_wanted_len;
        summary_beat.end_flag      = 1'b1;

        o_push = '0;
        if (i_valid) begin
            if (emit) begin
                o_push.first = value_beat;
                if (i_beat.last_byte) begin
                    o_push.second = summary_beat;
                    o_push.count  = 2'd2;
                end else begin
                    o_push.count  = 2'd1;
                end
            end else if (i_beat.last_byte) begin
                o_push.first = summary_beat;
                o_push.count = 2'd1;
            end
        end

        if (i_beat.last_byte) begin
            n_byte_pos   = '0;
            n_next_start = RECORDS_START;
            n_rec_type   = '0;
            n_rec_len    = '0;
            n_mode       = MODE_SKIP;
            n_id         = '0;
            n_words      = '0;
            n_res_seen   = RES_NONE;
            n_wnt_seen   = WNT_NONE;
            n_wanted_len = '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_beat.last_byte) |=> (r_byte_pos == 16'd0 && r_mode == MODE_SKIP))
        else $error("parser did not restart after the last beat");

    a_wanted_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_beat.last_byte && r_wnt_seen != WNT_NONE)
        |=> (r_wnt_seen != WNT_NONE))
        else $error("wanted record tracking lost within a message");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/qtrp_out_fifo.sv
// ============================================================================
// qtrp_out_fifo
// Result queue: takes up to two result beats per cycle from the step logic
// and hands them to the output channel one beat per cycle unless stalled.
// ============================================================================
`default_nettype none

module qtrp_out_fifo
    import qtrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_push_pair i_push,
    input  wire logic       i_stall,
    output logic            o_valid,
    output t_out_beat       o_beat,
    output logic            o_space
);

    t_out_beat r_mem [FIFO_DEPTH];

    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count,  n_count;
    logic [FIFO_PTR_W-1:0] wr_ptr_second;
    logic                  pop;

    assign wr_ptr_second = r_wr_ptr + FIFO_PTR_W'(1);
    assign o_valid       = (r_count != '0);
    assign o_beat        = r_mem[r_rd_ptr];
    assign o_space       = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop           = o_valid && !i_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push.count);
        n_rd_ptr = pop ? r_rd_ptr + FIFO_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + FIFO_CNT_W'(i_push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_second] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0)
        |-> (FIFO_CNT_W'(i_push.count) <= FIFO_CNT_W'(FIFO_DEPTH) - r_count))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0 && !pop)
        |=> (r_count == $past(r_count) + FIFO_CNT_W'($past(i_push.count))))
        else $error("result queue count does not follow pushes");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/qmi_tlv_response_parser.sv
// ============================================================================
// qmi_tlv_response_parser
// Response message parser: walks the records of a response one byte per beat,
// streams the value bytes of the wanted record and closes each message with a
// summary beat.
//
// Input channel (i_valid, o_stall, i_beat): one message byte per beat, the
// last byte marked by last_byte. Output channel (o_valid, i_stall, o_beat):
// value beats (kind 0) and one summary beat (kind 1, end_flag 1) per message.
// Configuration: i_cfg_we writes register i_cfg_index from i_cfg_data; write
// only while no message is in flight.
// Throughput: one input byte per cycle while o_stall is low. A byte yields
// at most two beats; the output drains one beat per cycle while i_stall is
// low, through a four-entry result queue. An accepted byte waits in an input
// register until the queue has room and is then parsed into the queue.
// Reset: synchronous, active low; clears the parser and the queue and restores
// wanted_type to 1 and value_capacity to 2.
// Stall: when i_stall holds the output, the queue fills and o_stall rises once
// fewer than two queue entries are free and a byte waits; no beat is lost.
// ============================================================================
`default_nettype none

module qmi_tlv_response_parser
    import qtrp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in_beat              i_beat,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out_beat                  o_beat
);

    logic       r_in_valid;
    t_in_beat   r_in_beat;
    logic       space;
    logic       advance;
    logic       accept;
    t_push_pair push;

    assign advance = r_in_valid && space;
    assign o_stall = r_in_valid && !space;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_beat <= i_beat;
        end
    end

    qtrp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (advance),
        .i_beat      (r_in_beat),
        .o_push      (push)
    );

    qtrp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_beat  (o_beat),
        .o_space (space)
    );

endmodule

`default_nettype wire
